### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the LZSS decoder.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### hw/rtl/lzpw_pkg.sv
// Shared constants, state encoding and control structs of the LZSS decoder.
// No dependencies.
`default_nettype none
package lzpw_pkg;

   localparam int LenBits     = 24;
   localparam int CfgBits     = 24;
   localparam int ByteBits    = 8;
   localparam int WinAddrBits = 12;
   localparam int WinDepth    = 1 << WinAddrBits;
   localparam int CntBits     = 5;

   localparam logic [WinAddrBits-1:0] WinStart   = 12'hFEE;
   localparam logic [WinAddrBits-1:0] WinLast    = 12'hFFF;
   localparam logic [WinAddrBits-1:0] RampUpBase = 12'hD00;
   localparam logic [WinAddrBits-1:0] RampDnBase = 12'hE00;
   localparam logic [WinAddrBits-1:0] ZeroBase   = 12'hF00;
   localparam logic [WinAddrBits-1:0] SpaceBase  = 12'hF80;
   localparam logic [ByteBits-1:0]    SpaceChar  = 8'h20;
   localparam logic [CntBits-1:0]     MinMatch   = 5'd3;
   localparam logic [3:0]             RepLast    = 4'd12;
   localparam logic [3:0]             FlagCount  = 4'd8;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_FLAG,
      ST_TOKEN,
      ST_MATCH_HI,
      ST_COPY
   } state_type;

   typedef struct packed {
      logic fill;
      logic start;
      logic load_flag;
      logic flag_held;
      logic literal;
      logic save_off;
      logic match_start;
      logic copy;
      logic token_done;
   } cmd_type;

   typedef struct packed {
      logic fill_end;
      logic stream_done;
      logic flag_bit;
      logic flags_more;
      logic out_free;
      logic copy_end;
   } status_type;

   // preset window content at a given address; run_val counts the 13-fold runs
   function automatic logic [ByteBits-1:0] preset_byte(
      input logic [WinAddrBits-1:0] addr,
      input logic [ByteBits-1:0]    run_val
   );
      logic [ByteBits-1:0] b;
      if (addr < RampUpBase) begin
         b = run_val;
      end else if (addr < RampDnBase) begin
         b = addr[ByteBits-1:0];
      end else if (addr < ZeroBase) begin
         b = ~addr[ByteBits-1:0];
      end else if (addr < SpaceBase) begin
         b = '0;
      end else if (addr < WinStart) begin
         b = SpaceChar;
      end else begin
         b = '0;
      end
      return b;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/lzpw_if.sv
// Handshake channels of the LZSS decoder: compressed input, output bytes, register write.
// Depends on lzpw_pkg.
`default_nettype none
interface lzpw_req_if;
   import lzpw_pkg::*;
   logic                valid;
   logic                ready;
   logic [ByteBits-1:0] in_byte;
   logic                start_stream;
   modport source (output valid, output in_byte, output start_stream, input ready);
   modport sink   (input valid, input in_byte, input start_stream, output ready);
endinterface

interface lzpw_rsp_if;
   import lzpw_pkg::*;
   logic                valid;
   logic                ready;
   logic [ByteBits-1:0] out_byte;
   logic                last;
   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface lzpw_csr_if;
   import lzpw_pkg::*;
   logic               valid;
   logic               ready;
   logic [CfgBits-1:0] output_length;
   modport source (output valid, output output_length, input ready);
   modport sink   (input valid, input output_length, output ready);
endinterface
`default_nettype wire

### hw/rtl/lzpw_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
`default_nettype none
module lzpw_ram #(
   parameter int Width = 8,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

### hw/rtl/lzpw_dp.sv
// Datapath of the LZSS decoder: window RAM, preset loader, parser registers, copy pipeline.
// Depends on lzpw_pkg, lzpw_if and lzpw_ram.
`default_nettype none
module lzpw_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  lzpw_pkg::cmd_type          cmd,
   output lzpw_pkg::status_type       st,
   input  logic [lzpw_pkg::ByteBits-1:0] in_byte,
   lzpw_rsp_if.source                 rsp,
   lzpw_csr_if.sink                   csr
);
   import lzpw_pkg::*;

   logic [LenBits-1:0]     len_ff, len_in;
   logic [LenBits-1:0]     produced_ff, produced_in;
   logic [WinAddrBits-1:0] wptr_ff, wptr_in;
   logic [ByteBits-1:0]    flag_bits_ff, flag_bits_in;
   logic [3:0]             flags_left_ff, flags_left_in;
   logic [ByteBits-1:0]    off_lo_ff, off_lo_in;
   logic [ByteBits-1:0]    held_ff, held_in;
   logic [WinAddrBits-1:0] src_ff, src_in;
   logic [CntBits-1:0]     rd_left_ff, rd_left_in;
   logic [CntBits-1:0]     em_left_ff, em_left_in;
   logic                   dv_ff, dv_in;
   logic                   byp_ff, byp_in;
   logic [ByteBits-1:0]    byp_data_ff, byp_data_in;
   logic [WinAddrBits-1:0] fill_addr_ff, fill_addr_in;
   logic [3:0]             rep_ff, rep_in;
   logic [ByteBits-1:0]    run_val_ff, run_val_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ByteBits-1:0]    out_byte_ff, out_byte_in;
   logic                   last_ff, last_in;

   logic                   out_free;
   logic                   copy_emit;
   logic                   copy_issue;
   logic                   emit;
   logic [ByteBits-1:0]    ram_rdata;
   logic [ByteBits-1:0]    copy_byte;
   logic [ByteBits-1:0]    emit_byte;
   logic [ByteBits-1:0]    flag_src;
   logic [LenBits-1:0]     produced_inc;
   logic [LenBits-1:0]     remain;
   logic [CntBits-1:0]     mlen;
   logic [CntBits-1:0]     mcount;
   logic                   ram_we;
   logic [WinAddrBits-1:0] ram_waddr;
   logic [ByteBits-1:0]    ram_wdata;

   assign out_free     = !rsp_valid_ff || rsp.ready;
   assign copy_emit    = cmd.copy && dv_ff && out_free;
   assign copy_issue   = cmd.copy && (rd_left_ff != '0) && (!dv_ff || copy_emit);
   assign emit         = cmd.literal || copy_emit;
   assign copy_byte    = byp_ff ? byp_data_ff : ram_rdata;
   assign emit_byte    = cmd.literal ? in_byte : copy_byte;
   assign flag_src     = cmd.flag_held ? held_ff : in_byte;
   assign produced_inc = produced_ff + LenBits'(1);
   assign remain       = len_ff - produced_ff;
   assign mlen         = {1'b0, in_byte[3:0]} + MinMatch;
   // copy length is cut at the end of the stream
   assign mcount       = (remain < {{(LenBits-CntBits){1'b0}}, mlen}) ? remain[CntBits-1:0]
                                                                       : mlen;

   assign ram_we    = cmd.fill || emit;
   assign ram_waddr = cmd.fill ? fill_addr_ff : wptr_ff;
   assign ram_wdata = cmd.fill ? preset_byte(fill_addr_ff, run_val_ff) : emit_byte;

   lzpw_ram #(
      .Width (ByteBits),
      .Depth (WinDepth)
   ) u_window (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (copy_issue),
      .raddr (src_ff),
      .rdata (ram_rdata)
   );

   always_comb begin
      len_in        = len_ff;
      produced_in   = produced_ff;
      wptr_in       = wptr_ff;
      flag_bits_in  = flag_bits_ff;
      flags_left_in = flags_left_ff;
      off_lo_in     = off_lo_ff;
      held_in       = held_ff;
      src_in        = src_ff;
      rd_left_in    = rd_left_ff;
      em_left_in    = em_left_ff;
      dv_in         = dv_ff;
      byp_in        = byp_ff;
      byp_data_in   = byp_data_ff;
      fill_addr_in  = fill_addr_ff;
      rep_in        = rep_ff;
      run_val_in    = run_val_ff;
      rsp_valid_in  = rsp.ready ? 1'b0 : rsp_valid_ff;
      out_byte_in   = out_byte_ff;
      last_in       = last_ff;

      if (csr.valid) begin
         len_in = csr.output_length[LenBits-1:0];
      end

      if (cmd.start) begin
         fill_addr_in  = '0;
         rep_in        = '0;
         run_val_in    = '0;
         wptr_in       = WinStart;
         flag_bits_in  = '0;
         flags_left_in = '0;
         off_lo_in     = '0;
         produced_in   = '0;
         held_in       = in_byte;
      end

      if (cmd.fill) begin
         fill_addr_in = fill_addr_ff + WinAddrBits'(1);
         if (rep_ff == RepLast) begin
            rep_in     = '0;
            run_val_in = run_val_ff + ByteBits'(1);
         end else begin
            rep_in = rep_ff + 4'd1;
         end
      end

      if (cmd.load_flag) begin
         flag_bits_in  = flag_src;
         flags_left_in = FlagCount;
      end

      if (cmd.save_off) begin
         off_lo_in = in_byte;
      end

      if (cmd.match_start) begin
         src_in     = {in_byte[7:4], off_lo_ff};
         rd_left_in = mcount;
         em_left_in = mcount;
         dv_in      = 1'b0;
         byp_in     = 1'b0;
      end

      if (copy_issue) begin
         src_in      = src_ff + WinAddrBits'(1);
         rd_left_in  = rd_left_ff - CntBits'(1);
         dv_in       = 1'b1;
         // the RAM returns old data when the byte being written is the one read
         byp_in      = copy_emit && (wptr_ff == src_ff);
         byp_data_in = copy_byte;
      end else if (copy_emit) begin
         dv_in = 1'b0;
      end

      if (copy_emit) begin
         em_left_in = em_left_ff - CntBits'(1);
      end

      if (emit) begin
         wptr_in      = wptr_ff + WinAddrBits'(1);
         produced_in  = produced_inc;
         rsp_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         last_in      = (produced_inc == len_ff);
      end

      if (cmd.token_done) begin
         flag_bits_in  = flag_bits_ff >> 1;
         flags_left_in = flags_left_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         produced_ff   <= '0;
         wptr_ff       <= WinStart;
         flag_bits_ff  <= '0;
         flags_left_ff <= '0;
         off_lo_ff     <= '0;
         rd_left_ff    <= '0;
         em_left_ff    <= '0;
         dv_ff         <= 1'b0;
         byp_ff        <= 1'b0;
         fill_addr_ff  <= '0;
         rep_ff        <= '0;
         run_val_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         len_ff        <= len_in;
         produced_ff   <= produced_in;
         wptr_ff       <= wptr_in;
         flag_bits_ff  <= flag_bits_in;
         flags_left_ff <= flags_left_in;
         off_lo_ff     <= off_lo_in;
         rd_left_ff    <= rd_left_in;
         em_left_ff    <= em_left_in;
         dv_ff         <= dv_in;
         byp_ff        <= byp_in;
         fill_addr_ff  <= fill_addr_in;
         rep_ff        <= rep_in;
         run_val_ff    <= run_val_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      held_ff     <= held_in;
      src_ff      <= src_in;
      byp_data_ff <= byp_data_in;
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
   end

   assign st.fill_end    = cmd.fill && (fill_addr_ff == WinLast);
   assign st.stream_done = (produced_ff >= len_ff);
   assign st.flag_bit    = flag_bits_ff[0];
   assign st.flags_more  = (flags_left_ff != 4'd1);
   assign st.out_free    = out_free;
   assign st.copy_end    = copy_emit && (em_left_ff == CntBits'(1));

   assign csr.ready    = 1'b1;
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.last     = last_ff;
endmodule
`default_nettype wire

### hw/rtl/lzpw_ctrl.sv
// Controller of the LZSS decoder: parse state machine, input handshake, datapath commands.
// Depends on lzpw_pkg and lzpw_if.
`default_nettype none
module lzpw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   lzpw_req_if.sink             req,
   input  lzpw_pkg::status_type st,
   output lzpw_pkg::cmd_type    cmd
);
   import lzpw_pkg::*;

   state_type state_ff, state_in;
   logic      held_ff, held_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         held_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      held_in   = held_ff;
      cmd       = '0;
      req.ready = 1'b0;

      unique case (state_ff)
         ST_FILL: begin
            cmd.fill = 1'b1;
            if (st.fill_end) begin
               held_in = 1'b0;
               // the item that started the stream is its flag byte
               if (held_ff && !st.stream_done) begin
                  cmd.load_flag = 1'b1;
                  cmd.flag_held = 1'b1;
                  state_in      = ST_TOKEN;
               end else begin
                  state_in = ST_FLAG;
               end
            end
         end
         ST_FLAG: begin
            req.ready = 1'b1;
            if (req.valid) begin
               priority if (req.start_stream) begin
                  cmd.start = 1'b1;
                  held_in   = 1'b1;
                  state_in  = ST_FILL;
               end else if (!st.stream_done) begin
                  cmd.load_flag = 1'b1;
                  state_in      = ST_TOKEN;
               end
            end
         end
         ST_TOKEN: begin
            req.ready = st.out_free;
            if (req.valid && st.out_free) begin
               priority if (req.start_stream) begin
                  cmd.start = 1'b1;
                  held_in   = 1'b1;
                  state_in  = ST_FILL;
               end else if (!st.stream_done) begin
                  if (st.flag_bit) begin
                     cmd.literal    = 1'b1;
                     cmd.token_done = 1'b1;
                     state_in       = st.flags_more ? ST_TOKEN : ST_FLAG;
                  end else begin
                     cmd.save_off = 1'b1;
                     state_in     = ST_MATCH_HI;
                  end
               end
            end
         end
         ST_MATCH_HI: begin
            req.ready = 1'b1;
            if (req.valid) begin
               priority if (req.start_stream) begin
                  cmd.start = 1'b1;
                  held_in   = 1'b1;
                  state_in  = ST_FILL;
               end else if (!st.stream_done) begin
                  cmd.match_start = 1'b1;
                  state_in        = ST_COPY;
               end
            end
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            if (st.copy_end) begin
               cmd.token_done = 1'b1;
               state_in       = st.flags_more ? ST_TOKEN : ST_FLAG;
            end
         end
         default: begin
            state_in = ST_FLAG;
         end
      endcase
   end
endmodule
`default_nettype wire

### hw/rtl/lzss_decoder_preset_window.sv
// LZSS decoder, 4 KiB window reloaded with a fixed preset at the start of each stream.
// The flag byte and the low match byte are each taken in one parse state. Literal: byte on rsp the next cycle.
// Match: the high byte starts the copy; each byte is read from the window RAM port and registered
// onto rsp, one byte per cycle while rsp is ready. A start_stream item adds a preset load.
// After reset the same preset load runs before the first item is taken;
// output_length resets to 0. Depends on lzpw_pkg, lzpw_if, lzpw_ctrl, lzpw_dp.
`default_nettype none
`include "assert_macros.svh"
module lzss_decoder_preset_window (
   input  logic       clock,
   input  logic       reset,
   lzpw_req_if.sink   req,
   lzpw_rsp_if.source rsp,
   lzpw_csr_if.sink   csr
);
   import lzpw_pkg::*;

   cmd_type    cmd;
   status_type st;

   lzpw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .st    (st),
      .cmd   (cmd)
   );

   lzpw_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .st      (st),
      .in_byte (req.in_byte),
      .rsp     (rsp),
      .csr     (csr)
   );

   `ASSERT_ALWAYS(a_no_accept_in_fill, clock, reset, cmd.fill |-> !(req.valid && req.ready), "item accepted during preset load")
   `ASSERT_NEVER(a_no_emit_past_len, clock, reset, (cmd.literal || cmd.match_start) && st.stream_done, "token decoded after stream complete")
   `ASSERT_ALWAYS(a_match_then_copy, clock, reset, cmd.match_start |=> cmd.copy, "match start not followed by copy")
endmodule
`default_nettype wire

### tb/tb_lzss_decoder_preset_window.sv
// Self-checking testbench for lzss_decoder_preset_window: directed table, then random streams.
// Expected output bytes come from the directed table or from a behavioural decoder kept inside this module.
// Depends on lzpw_pkg, lzpw_if and the decoder RTL.
module tb_lzss_decoder_preset_window;
   timeunit 1ns;
   timeprecision 1ps;
   import lzpw_pkg::*;

   localparam int LONG_STALL     = 400;
   localparam int SETTLE_CYCLES  = 4200;   // preset reload plus the longest copy
   localparam int DRAIN_CYCLES   = 60;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [7:0] PAD_SPACE = 8'h20;

   typedef enum logic [1:0] {PARSE_FLAG, PARSE_TOKEN, PARSE_MATCH_HI} parse_type;
   typedef enum bit {ROW_BYTE, ROW_LENGTH} row_kind_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } out_item_type;

   typedef struct {
      row_kind_type kind;
      logic [23:0]  len;
      logic [7:0]   in_byte;
      bit           start;
      bit           typed;
      logic [7:0]   exp_byte;
      bit           exp_last;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   lzpw_req_if req_ch();
   lzpw_rsp_if rsp_ch();
   lzpw_csr_if csr_ch();

   lzss_decoder_preset_window uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #4ns clock = ~clock;

   // behavioural decoder state
   logic [7:0]  win_model [4096];
   logic [11:0] model_wp;
   logic [7:0]  model_flags;
   logic [3:0]  model_flags_left;
   parse_type   model_phase;
   logic [7:0]  model_off_lo;
   logic [23:0] model_count;
   logic [23:0] model_len;

   out_item_type pending_out[$];
   int        mismatches = 0;
   int        src_idle_pct = 0;
   int        rsp_idle_pct = 0;
   int        stall_req = 0;
   int        stall_seen = 0;
   int        stall_left = 0;
   int        quiet_cycles = 0;
   logic [3:0] gen_off_hi = '0;

   stim_row_type directed [24] = '{
      '{ROW_BYTE,   24'd0,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},   // length 0: ignored
      '{ROW_BYTE,   24'd0,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_LENGTH, 24'd30, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE,   24'd0,  8'hF5, 1'b1, 1'b0, 8'h00, 1'b0},   // flags: L M L M L L L L
      '{ROW_BYTE,   24'd0,  8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0},
      '{ROW_BYTE,   24'd0,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},   // offset FFF, 18 bytes, wraps
      '{ROW_BYTE,   24'd0,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE,   24'd0,  8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
      '{ROW_BYTE,   24'd0,  8'hEE, 1'b0, 1'b0, 8'h00, 1'b0},   // reads back this stream's bytes
      '{ROW_BYTE,   24'd0,  8'hF0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE,   24'd0,  8'h80, 1'b0, 1'b1, 8'h80, 1'b0},
      '{ROW_BYTE,   24'd0,  8'h7F, 1'b0, 1'b1, 8'h7F, 1'b0},
      '{ROW_BYTE,   24'd0,  8'h01, 1'b0, 1'b1, 8'h01, 1'b0},
      '{ROW_BYTE,   24'd0,  8'hFE, 1'b0, 1'b1, 8'hFE, 1'b0},
      '{ROW_BYTE,   24'd0,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},   // fresh flag byte, all matches
      '{ROW_BYTE,   24'd0,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE,   24'd0,  8'h0F, 1'b0, 1'b0, 8'h00, 1'b0},   // 18 cut to 3 at the end
      '{ROW_BYTE,   24'd0,  8'h12, 1'b0, 1'b0, 8'h00, 1'b0},   // stream complete: ignored
      '{ROW_LENGTH, 24'd5,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},   // lowered below count
      '{ROW_BYTE,   24'd0,  8'h34, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_LENGTH, 24'd2,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE,   24'd0,  8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE,   24'd0,  8'h41, 1'b0, 1'b1, 8'h41, 1'b0},
      '{ROW_BYTE,   24'd0,  8'h5A, 1'b0, 1'b1, 8'h5A, 1'b1}
   };

   function automatic void restart_stream();
      int pos;
      int v;
      int k;
      pos = 0;
      for (v = 0; v < 256; v++)
         for (k = 0; k < 13; k++) begin
            win_model[pos] = 8'(v);
            pos++;
         end
      for (v = 0; v < 256; v++) begin
         win_model[pos] = 8'(v);
         pos++;
      end
      for (v = 0; v < 256; v++) begin
         win_model[pos] = 8'(255 - v);
         pos++;
      end
      for (k = 0; k < 128; k++) begin
         win_model[pos] = 8'h00;
         pos++;
      end
      for (k = 0; k < 110; k++) begin
         win_model[pos] = PAD_SPACE;
         pos++;
      end
      for (k = 0; k < 18; k++) begin
         win_model[pos] = 8'h00;
         pos++;
      end
      model_wp         = WinStart;
      model_flags      = '0;
      model_flags_left = '0;
      model_phase      = PARSE_FLAG;
      model_off_lo     = '0;
      model_count      = '0;
   endfunction

   function automatic void put_byte(logic [7:0] b, bit record);
      win_model[model_wp] = b;
      model_wp++;
      model_count++;
      if (record)
         pending_out.push_back('{b, model_count == model_len});
   endfunction

   function automatic void token_step();
      model_flags      = model_flags >> 1;
      model_flags_left = model_flags_left - 4'd1;
      model_phase      = (model_flags_left != 0) ? PARSE_TOKEN : PARSE_FLAG;
   endfunction

   // advance the decoder by one compressed byte, queueing the bytes it yields
   function automatic void decode_byte(logic [7:0] b, bit s, bit record);
      logic [11:0] rd;
      logic [23:0] n;
      logic [23:0] i;
      if (s)
         restart_stream();
      if (model_count >= model_len)
         return;
      case (model_phase)
         PARSE_TOKEN: begin
            if (model_flags[0]) begin
               put_byte(b, record);
               token_step();
            end else begin
               model_off_lo = b;
               model_phase  = PARSE_MATCH_HI;
            end
         end
         PARSE_MATCH_HI: begin
            rd = {b[7:4], model_off_lo};
            n  = 24'(b[3:0]) + 24'd3;
            if (n > model_len - model_count)
               n = model_len - model_count;
            for (i = 0; i < n; i++) begin
               put_byte(win_model[rd], record);
               rd++;
            end
            token_step();
         end
         default: begin
            model_flags      = b;
            model_flags_left = FlagCount;
            model_phase      = PARSE_TOKEN;
         end
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit s, input bit record);
      while ($urandom_range(99, 0) < src_idle_pct) begin
         @(negedge clock) req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.in_byte      <= b;
      req_ch.start_stream <= s;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      decode_byte(b, s, record);
   endtask

   task automatic set_output_length(input logic [23:0] v);
      @(negedge clock) req_ch.valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_ch.valid         <= 1'b1;
      csr_ch.output_length <= v;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      model_len = v;
      @(negedge clock) csr_ch.valid <= 1'b0;
   endtask

   // random well-formed tokens that follow the decoder's parse state, with some noise
   task automatic run_stream_phase(input logic [23:0] len, input int src_pct, input int rsp_pct,
                                   input int n_items, input int restarts,
                                   input bit hold_rsp, input bit drain_mid);
      logic [7:0]  b;
      logic [11:0] rd;
      bit          s;
      parse_type   view;
      int          k;
      int          budget;
      set_output_length(len);
      src_idle_pct = src_pct;
      rsp_idle_pct = rsp_pct;
      budget = restarts;
      if (hold_rsp)
         stall_req++;
      for (k = 0; k < n_items; k++) begin
         s = 1'b0;
         if (k == 0) begin
            s = 1'b1;
         end else if (budget > 0 &&
                      (model_count >= model_len || $urandom_range(39, 0) == 0)) begin
            s = 1'b1;
            budget--;
         end
         view = s ? PARSE_FLAG : model_phase;
         case (view)
            PARSE_TOKEN: begin
               if (model_flags[0]) begin
                  b = 8'($urandom);
               end else begin
                  // recent offsets give overlapping copies
                  if ($urandom_range(1, 0) == 1)
                     rd = model_wp - 12'($urandom_range(40, 1));
                  else
                     rd = 12'($urandom);
                  b = rd[7:0];
                  gen_off_hi = rd[11:8];
               end
            end
            PARSE_MATCH_HI: b = {gen_off_hi, 4'($urandom)};
            default:        b = 8'($urandom);
         endcase
         if ($urandom_range(19, 0) == 0)
            b = 8'($urandom);
         if (drain_mid && k == n_items / 2) begin
            @(negedge clock) req_ch.valid <= 1'b0;
            while (pending_out.size() != 0) @(posedge clock);
         end
         send_byte(b, s, 1'b1);
      end
   endtask

   always @(negedge clock) begin
      if (stall_req != stall_seen) begin
         stall_seen = stall_req;
         stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99, 0) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      out_item_type want;
      if (!reset && (rsp_ch.valid & rsp_ch.ready) === 1'b1) begin
         if (pending_out.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual out_byte %02h last %0b",
                     $time, rsp_ch.out_byte, rsp_ch.last);
            mismatches++;
         end else begin
            want = pending_out.pop_front();
            if (rsp_ch.out_byte !== want.out_byte) begin
               $display("%0t: out_byte expected %02h actual %02h", $time,
                        want.out_byte, rsp_ch.out_byte);
               mismatches++;
            end
            if (rsp_ch.last !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_ch.last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b1 || (req_ch.valid & req_ch.ready) === 1'b1 ||
          (rsp_ch.valid & rsp_ch.ready) === 1'b1 || (csr_ch.valid & csr_ch.ready) === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int r;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.in_byte       = '0;
      req_ch.start_stream  = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.output_length = '0;
      restart_stream();
      model_len = '0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      src_idle_pct = 19;
      rsp_idle_pct = 45;
      for (r = 0; r < $size(directed); r++) begin
         if (directed[r].kind == ROW_LENGTH) begin
            set_output_length(directed[r].len);
         end else begin
            send_byte(directed[r].in_byte, directed[r].start, !directed[r].typed);
            if (directed[r].typed)
               pending_out.push_back('{directed[r].exp_byte, directed[r].exp_last});
         end
      end

      run_stream_phase(24'hFFFFFF, 19, 45, 25, 2, 1'b1, 1'b0);
      run_stream_phase(24'd1, 19, 45, 10, 3, 1'b0, 1'b0);
      run_stream_phase(24'($urandom_range(400, 40)), 45, 19, 25, 2, 1'b0, 1'b1);
      run_stream_phase(24'd0, 45, 19, 4, 0, 1'b0, 1'b0);
      run_stream_phase(24'($urandom_range(600, 100)), 45, 19, 25, 2, 1'b0, 1'b0);
      run_stream_phase(24'($urandom_range(400, 40)), 0, 0, 20, 2, 1'b0, 1'b0);
      run_stream_phase(24'($urandom_range(2000, 200)), 0, 0, 20, 2, 1'b0, 1'b0);

      @(negedge clock) req_ch.valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
